// ===== rtl/fan_tach_autorange_divisor_macros.svh =====
// ----------------------------------------------------------------------------
// fan tachometer autorange divisor: assertion macros
// concurrent checks, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef FAN_TACH_AUTORANGE_DIVISOR_MACROS_SVH
`define FAN_TACH_AUTORANGE_DIVISOR_MACROS_SVH

`ifndef SYNTH
`define FTAD_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define FTAD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define FTAD_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`define FTAD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/ftad_pkg.sv =====
// ----------------------------------------------------------------------------
// ftad_pkg
// types and constants shared by the fan tachometer autorange divisor
// ----------------------------------------------------------------------------
`default_nettype none

package ftad_pkg;

    localparam int unsigned CODE_W    = 3;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned SPEED_W   = 21;
    localparam int unsigned DIVISOR_W = COUNT_W + (1 << CODE_W) - 1;

    localparam logic [SPEED_W-1:0] SPEED_NUM     = 21'd1350000;
    localparam logic [COUNT_W-1:0] STOPPED_COUNT = 8'hff;
    localparam logic [CODE_W-1:0]  MAX_CODE      = 3'd7;

    localparam logic [7:0] UPPER_RESET = 8'd192;
    localparam logic [7:0] LOWER_RESET = 8'd96;
    localparam logic [2:0] FANS_RESET  = 3'd5;

    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_PTR_W;

    localparam int unsigned BIT_IDX_W = $clog2(SPEED_W);

    typedef enum logic [1:0] {
        CFG_FANS_IN_USE    = 2'd0,
        CFG_UPPER_THRESHOLD = 2'd1,
        CFG_LOWER_THRESHOLD = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STOPPED = 2'd1,
        ST_ZERO    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         fan_number;
        logic [COUNT_W-1:0] tach_count;
    } t_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_rpm;
        logic [CODE_W-1:0]  code_used;
        logic [CODE_W-1:0]  code_next;
        logic               code_changed;
        logic [1:0]         status;
    } t_result;

    typedef struct packed {
        logic [2:0] fans_in_use;
        logic [7:0] upper_threshold;
        logic [7:0] lower_threshold;
    } t_cfg;

    typedef struct packed {
        logic               divide;
        logic [COUNT_W-1:0] tach_count;
        logic [CODE_W-1:0]  code_used;
        logic [CODE_W-1:0]  code_next;
        logic               code_changed;
        logic [1:0]         status;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/ftad_queue.sv =====
// ----------------------------------------------------------------------------
// ftad_queue
// short job queue between the classifier and the divider
// ----------------------------------------------------------------------------
`default_nettype none

module ftad_queue
    import ftad_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_fill;
    logic                   push_ok;
    logic                   pop_ok;

    assign o_full  = (r_fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ftad_front.sv =====
// ----------------------------------------------------------------------------
// ftad_front
// classifies a reading, keeps the per fan divisor codes and autoranges them
// ----------------------------------------------------------------------------
`default_nettype none

module ftad_front
    import ftad_pkg::*;
#(
    parameter int unsigned FAN_CHANNELS = 5
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_accept,
    input  wire t_item i_item,
    output t_job       o_job
);

    localparam int unsigned IDX_W = (FAN_CHANNELS > 1) ? $clog2(FAN_CHANNELS) : 1;

    logic [CODE_W-1:0] r_codes [FAN_CHANNELS];
    logic [IDX_W-1:0]  idx;
    logic              present;
    logic [CODE_W-1:0] used;
    logic [CODE_W-1:0] mid;
    logic [CODE_W-1:0] next;
    logic              go_up;
    logic              go_down;
    logic [1:0]        status;

    assign idx     = IDX_W'(i_item.fan_number);
    assign present = (i_item.fan_number < i_cfg.fans_in_use)
                  && ({1'b0, i_item.fan_number} < 4'(FAN_CHANNELS));
    assign used    = present ? r_codes[idx] : '0;
    assign go_up   = (i_item.tach_count > i_cfg.upper_threshold) && (used != MAX_CODE);
    assign mid     = used + CODE_W'(go_up);
    assign go_down = (i_item.tach_count < i_cfg.lower_threshold) && (mid != '0);
    assign next    = mid - CODE_W'(go_down);

    always_comb begin
        if (!present) begin
            status = ST_ABSENT;
        end else if (i_item.tach_count == STOPPED_COUNT) begin
            status = ST_STOPPED;
        end else if (i_item.tach_count == '0) begin
            status = ST_ZERO;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_job.divide       = (status == ST_OK);
        o_job.tach_count   = i_item.tach_count;
        o_job.code_used    = used;
        o_job.code_next    = present ? next : '0;
        o_job.code_changed = present && (next != used);
        o_job.status       = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FAN_CHANNELS; i++) begin
                r_codes[i] <= '0;
            end
        end else if (i_accept && present) begin
            r_codes[idx] <= next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ftad_back.sv =====
// ----------------------------------------------------------------------------
// ftad_back
// bit serial restoring divider for the speed and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ftad_back
    import ftad_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_result
);

    t_back_state            r_state;
    t_back_state            n_state;
    t_job                   r_job;
    t_job                   n_job;
    logic [DIVISOR_W-1:0]   r_div;
    logic [DIVISOR_W-1:0]   n_div;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   n_rem;
    logic [SPEED_W-1:0]     r_quot;
    logic [SPEED_W-1:0]     n_quot;
    logic [BIT_IDX_W-1:0]   r_bit;
    logic [BIT_IDX_W-1:0]   n_bit;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_result                r_out;
    t_result                n_out;
    logic [DIVISOR_W:0]     trial;
    logic                   fits;
    logic                   out_free;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign out_free = !r_out_valid || i_pop;
    assign trial    = {r_rem, SPEED_NUM[r_bit]};
    assign fits     = (trial >= {1'b0, r_div});

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_job_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_div     = DIVISOR_W'(i_job.tach_count) << i_job.code_used;
                    n_rem     = '0;
                    n_quot    = '0;
                    n_bit     = BIT_IDX_W'(SPEED_W - 1);
                    n_state   = i_job.divide ? BK_DIV : BK_HOLD;
                end
            end
            BK_DIV: begin
                n_rem  = fits ? DIVISOR_W'(trial - {1'b0, r_div}) : trial[DIVISOR_W-1:0];
                n_quot = {r_quot[SPEED_W-2:0], fits};
                n_bit  = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (out_free) begin
                    n_out.speed_rpm    = r_quot;
                    n_out.code_used    = r_job.code_used;
                    n_out.code_next    = r_job.code_next;
                    n_out.code_changed = r_job.code_changed;
                    n_out.status       = r_job.status;
                    n_out_valid        = 1'b1;
                    n_state            = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_bit  <= n_bit;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/fan_tach_autorange_divisor.sv =====
// ----------------------------------------------------------------------------
// fan_tach_autorange_divisor
// fan speed from tachometer counts with per fan divisor autoranging
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  item      in         push / full        i_item (t_item)
//  result    out        empty / pop        o_result (t_result)
//  config    in         i_cfg_we           i_cfg_addr, i_cfg_wdata
//
//  a reading to divide passes the back end in order: it is taken from the
//  queue, runs 21 divider steps (one quotient bit each), then loads the result;
//  stopped, zero or absent readings skip the divider
//  the front end takes a transaction per cycle until its two entry queue fills
//  synchronous reset clears the divisor codes and loads the config defaults
//  a result waiting on pop holds the divider after its last step
// ----------------------------------------------------------------------------
`default_nettype none
`include "fan_tach_autorange_divisor_macros.svh"

module fan_tach_autorange_divisor
    import ftad_pkg::*;
#(
    parameter int unsigned FAN_CHANNELS = 5
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_item      i_item,
    output logic            empty,
    input  wire logic       pop,
    output t_result         o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_addr,
    input  wire logic [7:0] i_cfg_wdata
);

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic accept;
    logic queue_empty;
    logic job_pop;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fans_in_use     <= FANS_RESET;
            r_cfg.upper_threshold <= UPPER_RESET;
            r_cfg.lower_threshold <= LOWER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FANS_IN_USE:     r_cfg.fans_in_use     <= i_cfg_wdata[2:0];
                CFG_UPPER_THRESHOLD: r_cfg.upper_threshold <= i_cfg_wdata;
                CFG_LOWER_THRESHOLD: r_cfg.lower_threshold <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ftad_front #(
        .FAN_CHANNELS (FAN_CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_item),
        .o_job    (front_job)
    );

    ftad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    ftad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!queue_empty),
        .i_job       (queue_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    `FTAD_ASSERT_IMPL(a_changed_matches, i_clk, i_rst_n, !empty,
        o_result.code_changed == (o_result.code_next != o_result.code_used),
        "code_changed disagrees with codes")
    `FTAD_ASSERT_IMPL(a_no_speed_on_fault, i_clk, i_rst_n,
        !empty && (o_result.status != ST_OK), o_result.speed_rpm == '0,
        "speed reported with a fault status")
    `FTAD_ASSERT_NEVER(a_absent_no_codes, i_clk, i_rst_n,
        !empty && (o_result.status == ST_ABSENT)
            && ((o_result.code_used != '0) || (o_result.code_next != '0)),
        "absent fan carries a code")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: fan tachometer autorange divisor testbench
// drives tachometer readings through the push side and pops speed results,
// predicting each result and the per fan divisor codes in a scoreboard; a
// directed opening is followed by randomised phases under several register
// settings and handshake idling patterns
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ftad_pkg::*;

    localparam int unsigned CHANNELS = 5;
    localparam int unsigned PHASES = 9;
    localparam int unsigned PHASE_READINGS = 76;

    localparam logic [2:0] PHASE_FANS  [PHASES] = '{3'd5, 3'd3, 3'd1, 3'd7, 3'd0,
                                                   3'd5, 3'd6, 3'd2, 3'd5};
    localparam logic [7:0] PHASE_UPPER [PHASES] = '{8'd192, 8'd255, 8'd0, 8'd128, 8'd100,
                                                   8'd160, 8'd30, 8'd250, 8'd192};
    localparam logic [7:0] PHASE_LOWER [PHASES] = '{8'd96, 8'd0, 8'd255, 8'd64, 8'd50,
                                                   8'd200, 8'd20, 8'd5, 8'd96};

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_item      i_item;
    logic       empty;
    logic       pop;
    t_result    o_result;
    logic       i_cfg_we;
    logic [1:0] i_cfg_addr;
    logic [7:0] i_cfg_wdata;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    class rpm_scoreboard;
        logic [2:0]  fans_in_use;
        logic [7:0]  upper_threshold;
        logic [7:0]  lower_threshold;
        logic [2:0]  codes [CHANNELS];
        t_result     awaited [$];
        int unsigned errors;
        int unsigned readings;
        int unsigned checked;

        function new();
            fans_in_use     = FANS_RESET;
            upper_threshold = UPPER_RESET;
            lower_threshold = LOWER_RESET;
            foreach (codes[i]) codes[i] = '0;
            errors   = 0;
            readings = 0;
            checked  = 0;
        endfunction

        function int unsigned present();
            return (fans_in_use > CHANNELS) ? CHANNELS : fans_in_use;
        endfunction

        function void write_register(t_cfg_index idx, logic [7:0] value);
            case (idx)
                CFG_FANS_IN_USE:     fans_in_use = value[2:0];
                CFG_UPPER_THRESHOLD: upper_threshold = value;
                CFG_LOWER_THRESHOLD: lower_threshold = value;
                default: ;
            endcase
        endfunction

        function void note_reading(t_item it);
            t_result     want;
            int unsigned fan;
            int unsigned count;
            int unsigned used;
            int unsigned nxt;
            fan   = it.fan_number;
            count = it.tach_count;
            want  = '0;
            readings++;
            if (fan >= present()) begin
                want.status = ST_ABSENT;
                awaited.push_back(want);
                return;
            end
            used = codes[fan];
            if (count == STOPPED_COUNT) begin
                want.status = ST_STOPPED;
            end else if (count == 0) begin
                want.status = ST_ZERO;
            end else begin
                want.status    = ST_OK;
                want.speed_rpm = SPEED_NUM / (count << used);
            end
            // rise first, then the fall test sees the risen code
            nxt = used;
            if (count > upper_threshold && nxt < MAX_CODE) nxt++;
            if (count < lower_threshold && nxt > 0) nxt--;
            codes[fan]        = nxt[2:0];
            want.code_used    = used[2:0];
            want.code_next    = nxt[2:0];
            want.code_changed = (nxt != used);
            awaited.push_back(want);
        endfunction

        function void field_ok(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result transaction %h, expected none", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            field_ok("speed_rpm", want.speed_rpm, got.speed_rpm);
            field_ok("code_used", want.code_used, got.code_used);
            field_ok("code_next", want.code_next, got.code_next);
            field_ok("code_changed", want.code_changed, got.code_changed);
            field_ok("status", want.status, got.status);
        endfunction

        function void flag_leftover();
            if (awaited.size() != 0) begin
                $display("%0t: %0d results never arrived, expected %h, actual none",
                         $time, awaited.size(), awaited[0]);
                errors++;
            end
        endfunction
    endclass

    rpm_scoreboard sb;

    fan_tach_autorange_divisor #(
        .FAN_CHANNELS(CHANNELS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // called at a falling edge; push stays high on return for back to back sends
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_reading(it);
        @(negedge i_clk);
    endtask

    task automatic send_reading(logic [2:0] fan, logic [7:0] count);
        t_item it;
        it.fan_number = fan;
        it.tach_count = count;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (sb.awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [2:0] fans, logic [7:0] upper, logic [7:0] lower);
        logic [7:0] fans_word;
        fans_word = {3'($urandom_range(7)), 2'($urandom_range(3)), fans};
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FANS_IN_USE;
        i_cfg_wdata <= fans_word;
        sb.write_register(CFG_FANS_IN_USE, fans_word);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_UPPER_THRESHOLD;
        i_cfg_wdata <= upper;
        sb.write_register(CFG_UPPER_THRESHOLD, upper);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_LOWER_THRESHOLD;
        i_cfg_wdata <= lower;
        sb.write_register(CFG_LOWER_THRESHOLD, lower);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [2:0] pick_fan();
        if (sb.present() > 0 && $urandom_range(4) != 0) begin
            return 3'($urandom_range(sb.present() - 1));
        end
        return 3'($urandom_range(7));
    endfunction

    function automatic logic [7:0] pick_count();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return sb.upper_threshold + 8'($urandom_range(2)) - 8'd1;
            4: return sb.lower_threshold + 8'($urandom_range(2)) - 8'd1;
            5, 6: return 8'($urandom_range(255, sb.upper_threshold));
            7: return 8'($urandom_range(sb.lower_threshold, 0));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly scattered readings, with runs on one fan to push its code to the ends
    task automatic send_random_phase(int unsigned n);
        int unsigned sent;
        int unsigned run_len;
        logic [2:0]  fan;
        logic        rising;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(7) == 0) begin
                run_len = $urandom_range(9, 4);
                fan     = pick_fan();
                rising  = 1'($urandom_range(1));
                repeat (run_len) begin
                    if (rising) begin
                        send_reading(fan, 8'($urandom_range(255, sb.upper_threshold)));
                    end else begin
                        send_reading(fan, 8'($urandom_range(sb.lower_threshold, 0)));
                    end
                    sent++;
                end
            end else begin
                send_reading(pick_fan(), pick_count());
                sent++;
            end
        end
    endtask

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.check_reading(o_result);
        end
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_FANS_IN_USE;
        i_cfg_wdata   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stopped fan climbs to the top code and holds there
        repeat (8) send_reading(3'd0, 8'd255);
        send_reading(3'd0, 8'd1);
        send_reading(3'd1, 8'd1);
        send_reading(3'd1, 8'd0);
        send_reading(3'd2, 8'd254);
        send_reading(3'd2, 8'd193);
        send_reading(3'd3, 8'd192);
        send_reading(3'd3, 8'd96);
        send_reading(3'd3, 8'd95);
        send_reading(3'd4, 8'd128);
        send_reading(3'd5, 8'd10);
        send_reading(3'd7, 8'd255);
        send_reading(3'd2, 8'd95);
        push <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            apply_settings(PHASE_FANS[p], PHASE_UPPER[p], PHASE_LOWER[p]);
            case (p * 3 / PHASES)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            send_random_phase(PHASE_READINGS);
            push <= 1'b0;
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        sb.flag_leftover();

        $display("covered %0d readings across %0d register settings, %0d results checked",
                 sb.readings, PHASES, sb.checked);
        $display("settings ran from no fans to all fans and from open to crossed thresholds");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
